### src/aes_pkg.sv
// Shared types, constants and round functions for the AES-128 ECB block.
// No dependencies.
package aes_pkg;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        last_block;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic        last_out;
    } aes_out_t;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_DECRYPT  = 2'd2;
    localparam int unsigned NUM_ROUNDS  = 10;
    localparam int unsigned RND_W       = 4;
    localparam logic [7:0] RCON_FIRST   = 8'h01;
    localparam logic [7:0] GF_POLY      = 8'h1b;

    typedef enum logic [1:0] {
        DP_IDLE,
        DP_EXPAND,
        DP_LOAD,
        DP_ROUND
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [RND_W-1:0] rnd;
        logic             last_round;
        logic             decrypt;
    } aes_cmd_t;

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [31:0] res;
        for (int r = 0; r < 4; r++) begin
            a[r]  = col[31-8*r -: 8];
            x2[r] = gf_dbl(a[r]);
            x4[r] = gf_dbl(x2[r]);
            x8[r] = gf_dbl(x4[r]);
            m9[r]  = x8[r] ^ a[r];
            m11[r] = x8[r] ^ x2[r] ^ a[r];
            m13[r] = x8[r] ^ x4[r] ^ a[r];
            m14[r] = x8[r] ^ x4[r] ^ x2[r];
        end
        for (int r = 0; r < 4; r++) begin
            if (inv) begin
                res[31-8*r -: 8] = m14[r] ^ m11[(r+1)%4] ^ m13[(r+2)%4] ^ m9[(r+3)%4];
            end else begin
                res[31-8*r -: 8] = x2[r] ^ x2[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4]
                                   ^ a[(r+3)%4];
            end
        end
        mix_col = res;
    endfunction

endpackage

### src/aes_datapath.sv
// Datapath for the AES-128 block: key schedule memory, key expansion and
// the shared round unit. Depends on aes_pkg.
module aes_datapath
    import aes_pkg::*;
(
    input  logic         aclk,
    input  aes_cmd_t     cmd,
    input  logic [127:0] key,
    input  aes_in_t      item_in,
    output aes_out_t     item_out
);

    logic [127:0] rk_mem [NUM_ROUNDS+1];
    logic [127:0] exp_reg;
    logic [127:0] exp_next;
    logic [7:0]   rcon_reg;
    logic [127:0] st_reg;
    logic [127:0] st_next;
    logic         last_reg;
    logic [127:0] rk_rd;
    logic [127:0] rk_use;
    logic [127:0] sub;
    logic [127:0] shf;
    logic [127:0] mix;
    logic [31:0]  tw;

    // key expansion: one round key per cycle
    always_comb begin
        tw = {exp_reg[23:0], exp_reg[31:24]};
        tw = {SBOX_FWD[tw[31:24]], SBOX_FWD[tw[23:16]], SBOX_FWD[tw[15:8]], SBOX_FWD[tw[7:0]]}
             ^ {rcon_reg, 24'h0};
        exp_next[127:96] = exp_reg[127:96] ^ tw;
        exp_next[95:64]  = exp_reg[95:64] ^ exp_next[127:96];
        exp_next[63:32]  = exp_reg[63:32] ^ exp_next[95:64];
        exp_next[31:0]   = exp_reg[31:0] ^ exp_next[63:32];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_EXPAND) begin
            if (cmd.rnd == '0) begin
                exp_reg  <= key;
                rcon_reg <= RCON_FIRST;
                rk_mem[0] <= key;
            end else begin
                exp_reg  <= exp_next;
                rcon_reg <= gf_dbl(rcon_reg);
                rk_mem[cmd.rnd] <= exp_next;
            end
        end
    end

    assign rk_rd = rk_mem[cmd.rnd];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sub[127-8*i -: 8] = cmd.decrypt ? SBOX_INV[st_reg[127-8*i -: 8]]
                                            : SBOX_FWD[st_reg[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shf[127-8*(4*c+r) -: 8] = cmd.decrypt
                    ? sub[127-8*(4*((c+4-r)%4)+r) -: 8]
                    : sub[127-8*(4*((c+r)%4)+r) -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            mix[127-32*c -: 32] = mix_col(shf[127-32*c -: 32], cmd.decrypt);
            rk_use[127-32*c -: 32] = (cmd.decrypt && !cmd.last_round)
                ? mix_col(rk_rd[127-32*c -: 32], 1'b1) : rk_rd[127-32*c -: 32];
        end
        case (cmd.op)
            DP_LOAD:  st_next = {item_in.data_high, item_in.data_low} ^ rk_rd;
            DP_ROUND: st_next = (cmd.last_round ? shf : mix) ^ rk_use;
            default:  st_next = st_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
        if (cmd.op == DP_LOAD) begin
            last_reg <= item_in.last_block;
        end
    end

    assign item_out = '{out_high: st_reg[127:64], out_low: st_reg[63:0], last_out: last_reg};

endmodule

### src/aes_control.sv
// Sequencer for the AES-128 block: key expansion, round count and handshakes.
// Depends on aes_pkg.
module aes_control
    import aes_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     keys_stale,
    input  logic     decrypt,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output logic     key_load,
    output aes_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [RND_W-1:0] cnt_reg;
    logic             ready_reg;
    logic             dec_reg;

    assign s_ready  = (state_reg == ST_IDLE) && ready_reg && !keys_stale;
    assign m_valid  = (state_reg == ST_DONE);
    assign key_load = (state_reg == ST_EXPAND) && (cnt_reg == '0);

    always_comb begin
        cmd.op = DP_IDLE;
        cmd.rnd = cnt_reg;
        cmd.decrypt = dec_reg;
        cmd.last_round = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.decrypt = decrypt;
                if (s_valid && s_ready) begin
                    cmd.op  = DP_LOAD;
                    cmd.rnd = decrypt ? RND_W'(NUM_ROUNDS) : '0;
                end
            end
            ST_EXPAND: cmd.op = DP_EXPAND;
            ST_ROUND: begin
                cmd.op = DP_ROUND;
                cmd.last_round = dec_reg ? (cnt_reg == '0) : (cnt_reg == RND_W'(NUM_ROUNDS));
            end
            default: cmd.op = DP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b0;
            dec_reg   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (keys_stale || !ready_reg) begin
                        state_reg <= ST_EXPAND;
                        cnt_reg   <= '0;
                        ready_reg <= 1'b0;
                    end else if (s_valid) begin
                        state_reg <= ST_ROUND;
                        dec_reg   <= decrypt;
                        cnt_reg   <= decrypt ? RND_W'(NUM_ROUNDS - 1) : RND_W'(1);
                    end
                end
                ST_EXPAND: begin
                    if (cnt_reg == RND_W'(NUM_ROUNDS)) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ROUND: begin
                    if (cmd.last_round) begin
                        state_reg <= ST_DONE;
                    end else begin
                        cnt_reg <= dec_reg ? cnt_reg - 1'b1 : cnt_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### src/aes128_block_cipher.sv
// Top level of the AES-128 ECB block: configuration registers, sequencer and datapath.
// Depends on aes_pkg, aes_control and aes_datapath.
//
// The initial key addition is done as an item is accepted, and ten passes through
// the single round unit follow; the result is then held until taken. The next item
// is accepted the cycle after the result is taken. After reset and after any key
// write, the first item waits while the key schedule is built, one round key per
// cycle, into an 11-entry round key store; a key write during that build makes it
// run again once it ends.
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  aes_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output aes_out_t    m_data
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        decrypt_reg;
    logic        stale_reg;
    logic        key_load;
    aes_cmd_t    cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            decrypt_reg  <= 1'b0;
            stale_reg    <= 1'b1;
        end else begin
            if (key_load) begin
                stale_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY_HIGH: begin
                        key_high_reg <= cfg_data;
                        stale_reg    <= 1'b1;
                    end
                    REG_KEY_LOW: begin
                        key_low_reg <= cfg_data;
                        stale_reg   <= 1'b1;
                    end
                    REG_DECRYPT: decrypt_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    aes_control u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .keys_stale (stale_reg),
        .decrypt    (decrypt_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .key_load   (key_load),
        .cmd        (cmd)
    );

    aes_datapath u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .key      ({key_high_reg, key_low_reg}),
        .item_in  (s_data),
        .item_out (m_data)
    );

endmodule

### src/aes_checker.sv
// Port-level checks for the AES-128 ECB block, bound to the top level.
// Depends on aes_pkg and aes128_block_cipher.
module aes_checker
    import aes_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input aes_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result waits");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("item accepted without a busy period");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("block not idle after reset");

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
